// ----- sv/lspg_pkg.sv -----
// ----------------------------------------------------------------------------
// lspg_pkg: shared types and constants of the LED strip pattern generator
// Holds pixel count, mode codes, register indexes and the front-to-back job.
// ----------------------------------------------------------------------------
package lspg_pkg;

    localparam int PIXEL_COUNT = 60;
    localparam int SIREN_HALF  = 15;
    localparam int PIX_W       = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

    typedef enum logic [2:0] {
        MODE_OFF     = 3'd0,
        MODE_RAINBOW = 3'd1,
        MODE_CHASE   = 3'd2,
        MODE_SIREN   = 3'd3,
        MODE_WIPE    = 3'd4,
        MODE_SCANNER = 3'd5,
        MODE_FADE    = 3'd6,
        MODE_NONE    = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_REVERSE  = 3'd1,
        REG_INTERVAL = 3'd2,
        REG_COLOR1   = 3'd3,
        REG_COLOR2   = 3'd4,
        REG_FADE     = 3'd5
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    // One frame job: everything the renderer needs, captured at classify time.
    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] index;
        logic [15:0] total;
        logic [23:0] color1;
        logic [23:0] color2;
        logic        wrapped;
    } t_job;

    function automatic logic [23:0] wheel_color(input logic [7:0] pos);
        logic [7:0] p;
        logic [9:0] p3;
        p = 8'd255 - pos;
        if (p < 8'd85) begin
            p3 = {2'b0, p} * 10'd3;
            wheel_color = {8'd255 - p3[7:0], 8'd0, p3[7:0]};
        end else if (p < 8'd170) begin
            p3 = {2'b0, p - 8'd85} * 10'd3;
            wheel_color = {8'd0, p3[7:0], 8'd255 - p3[7:0]};
        end else begin
            p3 = {2'b0, p - 8'd170} * 10'd3;
            wheel_color = {p3[7:0], 8'd255 - p3[7:0], 8'd0};
        end
    endfunction

    // Wheel offset of pixel i: i*256/60 = i*64/15, taken as (i*4370) >> 10,
    // which floors exactly for every 6-bit i
    function automatic logic [7:0] wheel_base(input logic [PIX_W-1:0] i);
        logic [18:0] v;
        v = {13'd0, i} * 19'd4370;
        wheel_base = v[17:10];
    endfunction

endpackage

// ----- sv/led_strip_pattern_generator_unit.sv -----
// Throughput: one pixel per cycle unless the receiver stalls; each pixel uses one
//   frame RAM read and one write; fade frames first run the 3-channel serial divider.
// Ticks are taken while the 2-entry job queue has room.
// Reset (i_rst_n low, synchronous) clears registers, counters and queue;
//   per-pixel written flags make the frame RAM read as black until written.
// ----------------------------------------------------------------------------
// led_strip_pattern_generator_unit: LED strip animation pattern generator
// Front accumulates ticks and sequences steps; back renders and emits pixels.
// ----------------------------------------------------------------------------
module led_strip_pattern_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] ticks_passed
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] pixel_number, [13:6] red, [21:14] green, [29:22] blue, [31:30] 0
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast,  // frame_end
    output logic        m_axis_tuser   // cycle_done
);
    logic           job_valid, job_ready;
    lspg_pkg::t_job job;
    logic [5:0]     pix;
    logic [23:0]    col;

    assign o_cfg_ready = 1'b1;

    lspg_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_tvalid(s_axis_tvalid), .o_tready(s_axis_tready), .i_ticks(s_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job));

    lspg_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job(job),
        .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_pixel(pix), .o_color(col), .o_last(m_axis_tlast), .o_done(m_axis_tuser));

    assign m_axis_tdata = {2'b00, col[7:0], col[15:8], col[23:16], pix};
endmodule

// ----- sv/lspg_ram.sv -----
// ----------------------------------------------------------------------------
// lspg_ram: generic simple dual-port RAM (one write port, one read port)
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lspg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- sv/lspg_front.sv -----
// ----------------------------------------------------------------------------
// lspg_front: tick accumulator and step sequencer
// Accepts ticks, decides when a frame is due, advances the step index and
// queues one render job per due frame while a pattern mode is selected.
// ----------------------------------------------------------------------------
module lspg_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tvalid,
    output logic               o_tready,
    input  logic [7:0]         i_ticks,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output lspg_pkg::t_job     o_job
);
    logic [2:0]  r_mode;
    logic        r_reverse;
    logic [15:0] r_interval;
    logic [23:0] r_color1, r_color2;
    logic [15:0] r_fade;
    logic [15:0] r_index, n_index;
    logic [15:0] r_total;
    logic [16:0] r_elapsed;
    logic [17:0] sum;
    logic [16:0] sat;
    logic        due, wrap;
    logic [15:0] inc;

    lspg_pkg::t_job r_q [lspg_pkg::QUEUE_DEPTH];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       accept, push, pop;

    assign o_tready = (r_cnt != 2'(lspg_pkg::QUEUE_DEPTH));
    assign accept   = i_tvalid && o_tready;
    assign sum      = {1'b0, r_elapsed} + {10'd0, i_ticks};
    assign sat      = sum[17] ? lspg_pkg::ELAPSED_MAX : sum[16:0];
    assign due      = sat > {1'b0, r_interval};
    assign push     = accept && due && r_mode != lspg_pkg::MODE_OFF
                      && r_mode != lspg_pkg::MODE_NONE;
    assign pop      = o_job_valid && i_job_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job    = r_q[r_rp];
    assign inc      = r_index + 16'd1;

    always_comb begin
        if (!r_reverse) begin
            wrap    = inc >= r_total;
            n_index = wrap ? 16'd0 : inc;
        end else begin
            wrap    = r_index <= 16'd1;
            n_index = wrap ? ((r_total == 16'd0) ? 16'd0 : r_total - 16'd1)
                           : r_index - 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= lspg_pkg::MODE_OFF;
            r_reverse <= 1'b0;
            r_interval <= 16'd0;
            r_color1 <= 24'd0;
            r_color2 <= 24'd0;
            r_fade <= 16'd1;
            r_index <= 16'd0;
            r_total <= 16'd0;
            r_elapsed <= 17'd0;
            r_cnt <= 2'd0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lspg_pkg::REG_MODE: begin
                        r_mode  <= i_cfg_data[2:0];
                        r_index <= 16'd0;
                        unique case (i_cfg_data[2:0])
                            lspg_pkg::MODE_RAINBOW: r_total <= 16'd255;
                            lspg_pkg::MODE_CHASE,
                            lspg_pkg::MODE_WIPE:
                                r_total <= 16'(lspg_pkg::PIXEL_COUNT);
                            lspg_pkg::MODE_SIREN:   r_total <= 16'd12;
                            lspg_pkg::MODE_SCANNER:
                                r_total <= 16'((lspg_pkg::PIXEL_COUNT - 1) * 2);
                            lspg_pkg::MODE_FADE:
                                r_total <= (r_fade == 16'd0) ? 16'd1 : r_fade;
                            default: r_total <= 16'd0;
                        endcase
                    end
                    lspg_pkg::REG_REVERSE:  r_reverse  <= i_cfg_data[0];
                    lspg_pkg::REG_INTERVAL: r_interval <= i_cfg_data[15:0];
                    lspg_pkg::REG_COLOR1:   r_color1   <= i_cfg_data;
                    lspg_pkg::REG_COLOR2:   r_color2   <= i_cfg_data;
                    lspg_pkg::REG_FADE:     r_fade     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_elapsed <= due ? 17'd0 : sat;
            end
            if (push) begin
                r_index <= n_index;
                r_wp    <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // Queue payload: render uses the index before advancing
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{mode: r_mode, index: r_index, total: r_total,
                           color1: r_color1, color2: r_color2, wrapped: wrap};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(lspg_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'(lspg_pkg::QUEUE_DEPTH) |-> !push)
        else $error("push into full queue");
    a_elapsed_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && due && !i_cfg_valid |=> r_elapsed == 17'd0)
        else $error("elapsed not cleared after frame");
endmodule

// ----- sv/lspg_back.sv -----
// ----------------------------------------------------------------------------
// lspg_back: frame renderer
// For fade jobs computes the fade color with a serial divider; then walks the pixels:
// read the stored color, update it, write it back and present it.
// ----------------------------------------------------------------------------
module lspg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    output logic               o_job_ready,
    input  lspg_pkg::t_job     i_job,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [5:0]         o_pixel,
    output logic [23:0]        o_color,
    output logic               o_last,
    output logic               o_done
);
    localparam int PW = lspg_pkg::PIX_W;

    lspg_pkg::t_state r_state, n_state;
    lspg_pkg::t_job   r_job;
    logic [PW-1:0] r_pix;       // pixel being read
    logic          r_rd;        // read data valid for r_pix
    logic [1:0]    r_ch;        // fade channel in division
    logic [4:0]    r_bit;
    logic [23:0]   r_num;
    logic [16:0]   r_rem;
    logic [23:0]   r_fade;
    logic [15:0]   t_eff, k_eff;
    logic [23:0]   prod_a, prod_b;

    logic [23:0] rdata, new_c, wdata, old_c;
    logic        we;
    logic [PW-1:0] raddr;
    logic [(1 << PW)-1:0] r_wr_ok;   // pixel written since reset

    // Output register
    logic r_ovalid;
    logic [PW-1:0] r_opix;
    logic [23:0] r_ocol;
    logic r_olast, r_odone;

    lspg_ram #(.WIDTH(24), .DEPTH(1 << PW)) u_frame (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_pix), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata));

    logic [PW-1:0] next_pix;
    logic          out_free, step;
    logic [1:0]    m3;
    logic [16:0]   idx_sum;
    logic [32:0]   q3p;
    logic          scan_hit;
    logic [7:0]    ca, cb;
    logic [16:0]   trial;
    logic [7:0]    sh;

    assign out_free = !r_ovalid || i_tready;
    assign step     = (r_state == lspg_pkg::ST_EMIT) && r_rd && out_free;
    assign next_pix = r_pix + PW'(1);
    assign raddr    = step ? next_pix : r_pix;
    assign old_c    = r_wr_ok[r_pix] ? rdata : 24'd0;
    assign t_eff    = (r_job.total == 16'd0) ? 16'd1 : r_job.total;
    assign k_eff    = (r_job.index > t_eff) ? t_eff : r_job.index;
    assign sh       = 8'(16 - 8 * int'(r_ch));
    assign ca       = 8'(r_job.color1 >> sh);
    assign cb       = 8'(r_job.color2 >> sh);
    assign prod_a   = {16'd0, ca} * {8'd0, t_eff - k_eff};
    assign prod_b   = {16'd0, cb} * {8'd0, k_eff};
    assign trial    = {r_rem[15:0], r_num[23]};
    assign idx_sum  = {11'd0, r_pix} + {1'b0, r_job.index};
    // Remainder by 3 through a reciprocal multiply, exact below 2^17
    assign q3p      = {16'd0, idx_sum} * 33'd43691;
    assign m3       = 2'(idx_sum - 17'(q3p[32:17]) * 17'd3);
    assign scan_hit = ({10'd0, r_pix} == r_job.index) ||
                      (r_job.total >= r_job.index &&
                       {10'd0, r_pix} == r_job.total - r_job.index);
    assign we       = step;
    assign wdata    = new_c;

    always_comb begin
        new_c = old_c;
        unique case (r_job.mode)
            lspg_pkg::MODE_RAINBOW:
                new_c = lspg_pkg::wheel_color(lspg_pkg::wheel_base(r_pix)
                                              + r_job.index[7:0]);
            lspg_pkg::MODE_CHASE:
                new_c = (m3 == 2'd0) ? r_job.color1 : r_job.color2;
            lspg_pkg::MODE_SIREN: begin
                if (int'(r_pix) < lspg_pkg::SIREN_HALF)
                    new_c = r_job.index[0] ? 24'd0 : r_job.color1;
                else if (int'(r_pix) < 2 * lspg_pkg::SIREN_HALF)
                    new_c = r_job.index[0] ? r_job.color2 : 24'd0;
            end
            lspg_pkg::MODE_WIPE:
                if ({10'd0, r_pix} == r_job.index) new_c = r_job.color1;
            lspg_pkg::MODE_SCANNER:
                new_c = scan_hit ? r_job.color1
                                 : {1'b0, old_c[23:17], 1'b0, old_c[15:9],
                                    1'b0, old_c[7:1]};
            lspg_pkg::MODE_FADE: new_c = r_fade;
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lspg_pkg::ST_IDLE:
                if (i_job_valid)
                    n_state = (i_job.mode == lspg_pkg::MODE_FADE)
                              ? lspg_pkg::ST_DIV : lspg_pkg::ST_EMIT;
            lspg_pkg::ST_DIV:
                if (r_ch == 2'd3) n_state = lspg_pkg::ST_EMIT;
            lspg_pkg::ST_EMIT:
                if (step && int'(r_pix) == lspg_pkg::PIXEL_COUNT - 1)
                    n_state = lspg_pkg::ST_IDLE;
            default: n_state = lspg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready = (r_state == lspg_pkg::ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lspg_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_rd     <= 1'b0;
            r_pix    <= '0;
            r_wr_ok  <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= step || (r_ovalid && !i_tready);
            if (r_state == lspg_pkg::ST_IDLE) begin
                r_pix <= '0;
                r_rd  <= 1'b0;
            end else if (r_state == lspg_pkg::ST_EMIT) begin
                // The read of the next pixel is issued on the step edge
                r_rd <= 1'b1;
                if (step) begin
                    r_pix          <= next_pix;
                    r_wr_ok[r_pix] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lspg_pkg::ST_IDLE && i_job_valid) begin
            r_job <= i_job;
            r_ch  <= 2'd0;
            r_bit <= 5'd0;
        end
        // Restoring divide, one quotient bit a cycle, 24 bits per channel
        if (r_state == lspg_pkg::ST_DIV) begin
            if (r_bit == 5'd0) begin
                r_num <= prod_a + prod_b;
                r_rem <= 17'd0;
                r_bit <= 5'd24;
            end else begin
                if (trial >= {1'b0, t_eff}) begin
                    r_rem <= trial - {1'b0, t_eff};
                    r_num <= {r_num[22:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_num <= {r_num[22:0], 1'b0};
                end
                r_bit <= r_bit - 5'd1;
                if (r_bit == 5'd1) begin
                    r_fade <= {r_fade[15:0], r_num[6:0],
                               trial >= {1'b0, t_eff}};
                    r_ch <= r_ch + 2'd1;
                end
            end
        end
        if (step) begin
            r_opix  <= r_pix;
            r_ocol  <= new_c;
            r_olast <= int'(r_pix) == lspg_pkg::PIXEL_COUNT - 1;
            r_odone <= int'(r_pix) == lspg_pkg::PIXEL_COUNT - 1 && r_job.wrapped;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_pixel  = r_opix;
    assign o_color  = r_ocol;
    assign o_last   = r_olast;
    assign o_done   = r_odone;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_tready |=> r_ovalid && $stable(r_opix))
        else $error("stalled pixel lost");
    a_pix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lspg_pkg::ST_EMIT |-> int'(r_pix) < lspg_pkg::PIXEL_COUNT)
        else $error("pixel counter beyond strip");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_odone |-> r_olast)
        else $error("cycle_done off last pixel");
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the LED strip pattern generator
// Drives tick requests and register writes, predicts every emitted pixel
// from its own pattern model and compares results in order, under several
// mixes of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb;

    localparam int  CLK_PERIOD  = 12;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  SETTLE      = 300;
    localparam int  DIR_ROWS    = 53;
    localparam int  NPIX        = lspg_pkg::PIXEL_COUNT;
    localparam logic [2:0] REG_UNUSED_A = 3'd6;
    localparam logic [2:0] REG_UNUSED_B = 3'd7;

    typedef struct {
        logic [5:0] pix;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
        logic       done;
    } t_pixel;

    typedef struct {
        logic        is_cfg;
        logic [2:0]  idx;
        logic [23:0] val;     // register data, or ticks in [7:0]
        logic        has_rgb;
        logic [23:0] rgb;     // color every pixel of the frame must carry
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    led_strip_pattern_generator_unit uut (.*);

    // model state
    logic [2:0]  mdl_mode;
    logic        mdl_rev;
    logic [15:0] mdl_interval;
    logic [23:0] mdl_c1;
    logic [23:0] mdl_c2;
    logic [15:0] mdl_fade;
    logic [23:0] mdl_frame [NPIX];
    logic [15:0] mdl_idx;
    logic [15:0] mdl_total;
    logic [16:0] mdl_elapsed;

    t_pixel pending_pixels [$];
    int     err_cnt;
    int     cycle_cnt;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_cycles;

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{1, lspg_pkg::REG_INTERVAL, 24'd0,       0, 0},
        '{1, lspg_pkg::REG_COLOR1,   24'hFFFFFF,  0, 0},
        '{1, lspg_pkg::REG_COLOR2,   24'hFFFFFF,  0, 0},
        '{1, lspg_pkg::REG_FADE,     24'd0,       0, 0},
        '{1, lspg_pkg::REG_MODE,     lspg_pkg::MODE_FADE,    0, 0},
        '{0, 3'd0,                   24'd1,       1, 24'hFFFFFF},
        '{0, 3'd0,                   24'd255,     1, 24'hFFFFFF},
        '{1, lspg_pkg::REG_COLOR1,   24'd0,       0, 0},
        '{1, lspg_pkg::REG_COLOR2,   24'd0,       0, 0},
        '{0, 3'd0,                   24'd128,     1, 24'h000000},
        '{1, lspg_pkg::REG_COLOR1,   24'hFF0000,  0, 0},
        '{1, lspg_pkg::REG_COLOR2,   24'h0000FF,  0, 0},
        '{1, lspg_pkg::REG_FADE,     24'hFFFF,    0, 0},
        '{1, lspg_pkg::REG_MODE,     lspg_pkg::MODE_FADE,    0, 0},
        '{0, 3'd0,                   24'd3,       0, 0},
        '{1, lspg_pkg::REG_FADE,     24'd4,       0, 0},   // no effect until mode write
        '{0, 3'd0,                   24'd64,      0, 0},
        '{1, lspg_pkg::REG_MODE,     lspg_pkg::MODE_RAINBOW, 0, 0},
        '{0, 3'd0,                   24'd1,       0, 0},
        '{0, 3'd0,                   24'd2,       0, 0},
        '{1, lspg_pkg::REG_MODE,     lspg_pkg::MODE_CHASE,   0, 0},
        '{0, 3'd0,                   24'd5,       0, 0},
        '{0, 3'd0,                   24'd5,       0, 0},
        '{1, lspg_pkg::REG_MODE,     lspg_pkg::MODE_SIREN,   0, 0},
        '{0, 3'd0,                   24'd7,       0, 0},
        '{0, 3'd0,                   24'd9,       0, 0},
        '{1, lspg_pkg::REG_MODE,     lspg_pkg::MODE_WIPE,    0, 0},
        '{0, 3'd0,                   24'd1,       0, 0},
        '{0, 3'd0,                   24'd1,       0, 0},
        '{1, lspg_pkg::REG_MODE,     lspg_pkg::MODE_SCANNER, 0, 0},
        '{0, 3'd0,                   24'd17,      0, 0},
        '{0, 3'd0,                   24'd33,      0, 0},
        '{1, lspg_pkg::REG_REVERSE,  24'd1,       0, 0},
        '{0, 3'd0,                   24'd1,       0, 0},
        '{0, 3'd0,                   24'd1,       0, 0},
        '{0, 3'd0,                   24'd1,       0, 0},
        '{1, lspg_pkg::REG_MODE,     lspg_pkg::MODE_SIREN,   0, 0},
        '{0, 3'd0,                   24'd1,       0, 0},
        '{1, lspg_pkg::REG_REVERSE,  24'd0,       0, 0},
        '{1, lspg_pkg::REG_MODE,     lspg_pkg::MODE_OFF,     0, 0},
        '{0, 3'd0,                   24'd2,       0, 0},
        '{1, lspg_pkg::REG_MODE,     lspg_pkg::MODE_NONE,    0, 0},
        '{0, 3'd0,                   24'd4,       0, 0},
        '{1, REG_UNUSED_A,           24'd5,       0, 0},
        '{1, REG_UNUSED_B,           24'd5,       0, 0},
        '{1, lspg_pkg::REG_INTERVAL, 24'hFFFF,    0, 0},
        '{1, lspg_pkg::REG_MODE,     lspg_pkg::MODE_CHASE,   0, 0},
        '{0, 3'd0,                   24'd255,     0, 0},
        '{0, 3'd0,                   24'd255,     0, 0},
        '{1, lspg_pkg::REG_INTERVAL, 24'd0,       0, 0},
        '{0, 3'd0,                   24'd1,       0, 0},
        '{1, lspg_pkg::REG_MODE,     lspg_pkg::MODE_WIPE,    0, 0},
        '{0, 3'd0,                   24'd1,       0, 0}
    };

    function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
        logic [7:0] p;
        p = 8'd255 - pos;
        if (p < 8'd85)
            return {8'(255 - 3 * p), 8'd0, 8'(3 * p)};
        if (p < 8'd170) begin
            p = p - 8'd85;
            return {8'd0, 8'(3 * p), 8'(255 - 3 * p)};
        end
        p = p - 8'd170;
        return {8'(3 * p), 8'(255 - 3 * p), 8'd0};
    endfunction

    function automatic logic [7:0] fade_level(input logic [7:0] a, input logic [7:0] b,
                                              input int k, input int t);
        return 8'((int'(a) * (t - k) + int'(b) * k) / t);
    endfunction

    task automatic apply_reg(input logic [2:0] idx, input logic [23:0] v);
        case (idx)
            lspg_pkg::REG_MODE: begin
                mdl_mode = v[2:0];
                mdl_idx  = 16'd0;
                case (v[2:0])
                    lspg_pkg::MODE_RAINBOW: mdl_total = 16'd255;
                    lspg_pkg::MODE_CHASE:   mdl_total = 16'(NPIX);
                    lspg_pkg::MODE_SIREN:   mdl_total = 16'd12;
                    lspg_pkg::MODE_WIPE:    mdl_total = 16'(NPIX);
                    lspg_pkg::MODE_SCANNER: mdl_total = 16'((NPIX - 1) * 2);
                    lspg_pkg::MODE_FADE:
                        mdl_total = (mdl_fade == 16'd0) ? 16'd1 : mdl_fade;
                    default:                mdl_total = 16'd0;
                endcase
            end
            lspg_pkg::REG_REVERSE:  mdl_rev = v[0];
            lspg_pkg::REG_INTERVAL: mdl_interval = v[15:0];
            lspg_pkg::REG_COLOR1:   mdl_c1 = v;
            lspg_pkg::REG_COLOR2:   mdl_c2 = v;
            lspg_pkg::REG_FADE:     mdl_fade = v[15:0];
            default: ;
        endcase
    endtask

    // If due in a pattern mode, render the model frame, advance the step, queue pixels.
    task automatic predict_frame(input logic [7:0] ticks);
        int          t, k, s;
        logic [23:0] c;
        logic        wrapped;
        t_pixel      px;
        mdl_elapsed = (int'(mdl_elapsed) + ticks > 17'h1FFFF) ? 17'h1FFFF
                                                               : mdl_elapsed + ticks;
        if (mdl_elapsed <= {1'b0, mdl_interval})
            return;
        mdl_elapsed = 17'd0;
        if (mdl_mode == lspg_pkg::MODE_OFF || mdl_mode == lspg_pkg::MODE_NONE)
            return;
        case (mdl_mode)
            lspg_pkg::MODE_RAINBOW:
                for (int i = 0; i < NPIX; i++)
                    mdl_frame[i] = wheel_rgb(8'(i * 256 / NPIX + mdl_idx));
            lspg_pkg::MODE_CHASE:
                for (int i = 0; i < NPIX; i++)
                    mdl_frame[i] = ((i + mdl_idx) % 3 == 0) ? mdl_c1 : mdl_c2;
            lspg_pkg::MODE_SIREN:
                for (int i = 0; i < lspg_pkg::SIREN_HALF; i++) begin
                    mdl_frame[i] = mdl_idx[0] ? 24'd0 : mdl_c1;
                    mdl_frame[i + lspg_pkg::SIREN_HALF] = mdl_idx[0] ? mdl_c2 : 24'd0;
                end
            lspg_pkg::MODE_WIPE:
                if (mdl_idx < NPIX)
                    mdl_frame[mdl_idx] = mdl_c1;
            lspg_pkg::MODE_SCANNER:
                for (int i = 0; i < NPIX; i++) begin
                    if (i == mdl_idx || (mdl_total >= mdl_idx && i == mdl_total - mdl_idx))
                        mdl_frame[i] = mdl_c1;
                    else
                        mdl_frame[i] = {1'b0, mdl_frame[i][23:17], 1'b0,
                                        mdl_frame[i][15:9], 1'b0, mdl_frame[i][7:1]};
                end
            default: begin
                t = (mdl_total == 0) ? 1 : int'(mdl_total);
                k = (mdl_idx > t) ? t : int'(mdl_idx);
                c = {fade_level(mdl_c1[23:16], mdl_c2[23:16], k, t),
                     fade_level(mdl_c1[15:8], mdl_c2[15:8], k, t),
                     fade_level(mdl_c1[7:0], mdl_c2[7:0], k, t)};
                for (int i = 0; i < NPIX; i++)
                    mdl_frame[i] = c;
            end
        endcase
        if (!mdl_rev) begin
            s = int'(mdl_idx) + 1;
            wrapped = (16'(s) >= mdl_total);
            mdl_idx = wrapped ? 16'd0 : 16'(s);
        end else begin
            wrapped = (mdl_idx <= 16'd1);
            if (wrapped)
                mdl_idx = (mdl_total == 16'd0) ? 16'd0 : mdl_total - 16'd1;
            else
                mdl_idx = mdl_idx - 16'd1;
        end
        for (int i = 0; i < NPIX; i++) begin
            px.pix   = 6'(i);
            px.red   = mdl_frame[i][23:16];
            px.green = mdl_frame[i][15:8];
            px.blue  = mdl_frame[i][7:0];
            px.last  = (i == NPIX - 1);
            px.done  = px.last && wrapped;
            pending_pixels.push_back(px);
        end
    endtask

    // Hold until every queued pixel has come out, then let the block settle.
    task automatic wait_idle();
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one tick request; on acceptance run the model. Valid stays up
    // into the next request unless an idle gap is drawn.
    task automatic send_tick(input logic [7:0] ticks);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ticks;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_frame(ticks);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic random_phase(input int n_items);
        logic [2:0] md;
        write_reg(lspg_pkg::REG_REVERSE, 24'($urandom_range(1)));
        write_reg(lspg_pkg::REG_INTERVAL,
                  ($urandom_range(9) == 0) ? 24'd300 : 24'($urandom_range(4)));
        write_reg(lspg_pkg::REG_COLOR1, 24'($urandom));
        write_reg(lspg_pkg::REG_COLOR2, 24'($urandom));
        case ($urandom_range(3))
            0: write_reg(lspg_pkg::REG_FADE, 24'd0);
            1: write_reg(lspg_pkg::REG_FADE, 24'hFFFF);
            default: write_reg(lspg_pkg::REG_FADE, 24'($urandom_range(1, 20)));
        endcase
        md = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 6));
        write_reg(lspg_pkg::REG_MODE, 24'(md));
        if ($urandom_range(3) == 0)
            write_reg(lspg_pkg::REG_FADE, 24'($urandom_range(1, 9)));
        for (int i = 0; i < n_items; i++)
            send_tick(($urandom_range(3) == 0) ? 8'd1 : 8'($urandom_range(1, 255)));
        end_burst();
        wait_idle();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    always @(negedge i_clk) begin
        if (i_rst_n)
            m_axis_tready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                err_cnt = err_cnt + 1;
                if (err_cnt <= 10)
                    $display("unexpected pixel: tdata=%h last=%b user=%b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata[5:0] !== want.pix || m_axis_tdata[13:6] !== want.red ||
                    m_axis_tdata[21:14] !== want.green || m_axis_tdata[29:22] !== want.blue ||
                    m_axis_tlast !== want.last || m_axis_tuser !== want.done) begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= 10)
                        $display("pixel mismatch: exp pix=%0d rgb=%h%h%h last=%b done=%b, got pix=%0d rgb=%h%h%h last=%b done=%b",
                                 want.pix, want.red, want.green, want.blue, want.last,
                                 want.done, m_axis_tdata[5:0], m_axis_tdata[13:6],
                                 m_axis_tdata[21:14], m_axis_tdata[29:22],
                                 m_axis_tlast, m_axis_tuser);
                end
            end
        end
    end

    initial begin
        int first;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'd0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = 3'd0;
        i_cfg_data     = 24'd0;
        m_axis_tready  = 1'b0;
        err_cnt        = 0;
        cycle_cnt      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        mdl_fade = 16'd1;
        apply_reg(lspg_pkg::REG_MODE, 24'(lspg_pkg::MODE_OFF));
        mdl_rev = 1'b0; mdl_interval = 16'd0; mdl_c1 = 24'd0; mdl_c2 = 24'd0;
        mdl_elapsed = 17'd0;
        foreach (mdl_frame[i]) mdl_frame[i] = 24'd0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed walk
        foreach (dir_tab[r]) begin
            if (dir_tab[r].is_cfg) begin
                end_burst();
                wait_idle();
                write_reg(dir_tab[r].idx, dir_tab[r].val);
            end else begin
                first = pending_pixels.size();
                send_tick(dir_tab[r].val[7:0]);
                if (dir_tab[r].has_rgb)
                    for (int i = first; i < pending_pixels.size(); i++) begin
                        pending_pixels[i].red   = dir_tab[r].rgb[23:16];
                        pending_pixels[i].green = dir_tab[r].rgb[15:8];
                        pending_pixels[i].blue  = dir_tab[r].rgb[7:0];
                    end
            end
        end
        end_burst();
        wait_idle();

        send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(11); random_phase(11);
        send_idle_pct = 71; recv_stall_pct = 0;  random_phase(11); random_phase(11);
        send_idle_pct = 0;  recv_stall_pct = 71; random_phase(11); random_phase(11);
        send_idle_pct = 15; recv_stall_pct = 15; random_phase(11); random_phase(11);

        // back-pressure: receiver holds off while requests keep coming
        send_idle_pct = 0; recv_stall_pct = 0;
        write_reg(lspg_pkg::REG_INTERVAL, 24'd0);
        write_reg(lspg_pkg::REG_MODE, 24'(lspg_pkg::MODE_CHASE));
        hold_cycles = 1500;
        for (int i = 0; i < 8; i++)
            send_tick(8'($urandom_range(1, 255)));
        end_burst();
        wait_idle();

        if (err_cnt == 0 && pending_pixels.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
